// ===== rtl/dpf_pkg.sv =====
package dpf_pkg;

    // Limits of the close-range run that forces occupancy.
    localparam logic [15:0] CLOSE_NEAR_MM = 16'd100;
    localparam logic [15:0] CLOSE_FAR_MM  = 16'd300;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] CLOSE_COUNT_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE_MM          = 3'd0,
        REG_DELTA_WAKE_MM         = 3'd1,
        REG_LOCK_TIME_MS          = 3'd2,
        REG_ARRIVAL_DEBOUNCE_MS   = 3'd3,
        REG_CLOSE_SAMPLES_NEEDED  = 3'd4,
        REG_DEPARTURE_DEBOUNCE_MS = 3'd5,
        REG_ARRIVE_DIST_MM        = 3'd6,
        REG_DEPART_DIST_MM        = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] tolerance_mm;
        logic [15:0] delta_wake_mm;
        logic [31:0] lock_time_ms;
        logic [31:0] arrival_debounce_ms;
        logic [7:0]  close_samples_needed;
        logic [31:0] departure_debounce_ms;
        logic [15:0] arrive_dist_mm;
        logic [15:0] depart_dist_mm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        tolerance_mm:          16'd50,
        delta_wake_mm:         16'd150,
        lock_time_ms:          32'd5000,
        arrival_debounce_ms:   32'd1000,
        close_samples_needed:  8'd3,
        departure_debounce_ms: 32'd10000,
        arrive_dist_mm:        16'd800,
        depart_dist_mm:        16'd1000
    };

    typedef struct packed {
        logic        occupied;
        logic        wake;
        logic        baseline_locked_out;
        logic [15:0] baseline_mm;
    } result_t;

endpackage

// ===== rtl/dpf_in_if.sv =====
interface dpf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_mm;
    logic [31:0] now_ms;

    modport source (output valid, output distance_mm, output now_ms, input ready);
    modport sink   (input valid, input distance_mm, input now_ms, output ready);
endinterface

// ===== rtl/dpf_out_if.sv =====
interface dpf_out_if;
    logic        valid;
    logic        ready;
    logic        occupied;
    logic        wake;
    logic        baseline_locked_out;
    logic [15:0] baseline_mm;

    modport source (output valid, output occupied, output wake,
                    output baseline_locked_out, output baseline_mm, input ready);
    modport sink   (input valid, input occupied, input wake,
                    input baseline_locked_out, input baseline_mm, output ready);
endinterface

// ===== rtl/dpf_cfg_regs.sv =====
module dpf_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output dpf_pkg::cfg_t                  cfg
);

    dpf_pkg::cfg_t cfg_reg;
    dpf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (dpf_pkg::cfg_idx_t'(cfg_index))
                dpf_pkg::REG_TOLERANCE_MM:
                    cfg_next.tolerance_mm = cfg_wdata[15:0];
                dpf_pkg::REG_DELTA_WAKE_MM:
                    cfg_next.delta_wake_mm = cfg_wdata[15:0];
                dpf_pkg::REG_LOCK_TIME_MS:
                    cfg_next.lock_time_ms = cfg_wdata[31:0];
                dpf_pkg::REG_ARRIVAL_DEBOUNCE_MS:
                    cfg_next.arrival_debounce_ms = cfg_wdata[31:0];
                dpf_pkg::REG_CLOSE_SAMPLES_NEEDED:
                    cfg_next.close_samples_needed = cfg_wdata[7:0];
                dpf_pkg::REG_DEPARTURE_DEBOUNCE_MS:
                    cfg_next.departure_debounce_ms = cfg_wdata[31:0];
                dpf_pkg::REG_ARRIVE_DIST_MM:
                    cfg_next.arrive_dist_mm = cfg_wdata[15:0];
                dpf_pkg::REG_DEPART_DIST_MM:
                    cfg_next.depart_dist_mm = cfg_wdata[15:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dpf_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dpf_core.sv =====
module dpf_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [15:0]      distance_mm,
    input  logic [31:0]      now_ms,
    input  dpf_pkg::cfg_t    cfg,
    output dpf_pkg::result_t result
);

    typedef struct packed {
        logic        present;
        logic [7:0]  close_count;
        logic        close_hold;
        logic        arrival_pending;
        logic [31:0] arrival_start;
        logic        departure_pending;
        logic [31:0] departure_start;
        logic [15:0] baseline_distance;
        logic [31:0] baseline_start;
        logic        baseline_locked;
    } state_t;

    state_t st_reg;
    state_t st_next;

    logic        far;
    logic        near;
    logic [7:0]  count_inc;
    logic        close_fire;
    logic [31:0] arrival_elapsed;
    logic [31:0] departure_elapsed;
    logic [31:0] baseline_elapsed;
    logic [16:0] lean_sum;
    logic        lean_in;
    logic [15:0] diff;
    logic        wake;

    assign far        = distance_mm >= dpf_pkg::CLOSE_FAR_MM;
    assign near       = distance_mm <= dpf_pkg::CLOSE_NEAR_MM;
    assign count_inc  = (st_reg.close_count == dpf_pkg::CLOSE_COUNT_MAX) ?
                        st_reg.close_count : st_reg.close_count + 8'd1;
    assign close_fire = !far && near && !st_reg.close_hold &&
                        (count_inc >= cfg.close_samples_needed);

    // Elapsed times wrap with the millisecond counter.
    assign arrival_elapsed   = now_ms - st_reg.arrival_start;
    assign departure_elapsed = now_ms - st_reg.departure_start;
    assign baseline_elapsed  = now_ms - st_reg.baseline_start;

    assign lean_sum = {1'b0, distance_mm} + {1'b0, cfg.delta_wake_mm};
    assign lean_in  = st_reg.baseline_locked && (lean_sum <= {1'b0, st_reg.baseline_distance});
    assign diff     = (distance_mm >= st_reg.baseline_distance) ?
                      distance_mm - st_reg.baseline_distance :
                      st_reg.baseline_distance - distance_mm;

    always_comb
    begin
        st_next = st_reg;
        wake    = 1'b0;

        if (far)
        begin
            st_next.close_count = 8'd0;
            st_next.close_hold  = 1'b0;
        end
        else if (near && !st_reg.close_hold)
        begin
            st_next.close_count = count_inc;
        end

        if (close_fire)
        begin
            st_next.present         = 1'b1;
            st_next.arrival_start   = 32'd0;
            st_next.arrival_pending = 1'b0;
            st_next.close_hold      = 1'b1;
            st_next.close_count     = 8'd0;
            wake                    = 1'b1;
        end
        else if (!st_reg.present)
        begin
            st_next.departure_start   = 32'd0;
            st_next.departure_pending = 1'b0;
            if (distance_mm <= cfg.arrive_dist_mm)
            begin
                if (!st_reg.arrival_pending)
                begin
                    st_next.arrival_start   = now_ms;
                    st_next.arrival_pending = 1'b1;
                end
                else if (arrival_elapsed >= cfg.arrival_debounce_ms)
                begin
                    st_next.present           = 1'b1;
                    st_next.baseline_distance = distance_mm;
                    st_next.baseline_start    = now_ms;
                    st_next.baseline_locked   = 1'b0;
                    st_next.arrival_start     = 32'd0;
                    st_next.arrival_pending   = 1'b0;
                    wake                      = 1'b1;
                end
            end
            else
            begin
                st_next.arrival_start   = 32'd0;
                st_next.arrival_pending = 1'b0;
            end
        end
        else
        begin
            st_next.arrival_start   = 32'd0;
            st_next.arrival_pending = 1'b0;
            if (distance_mm > cfg.depart_dist_mm)
            begin
                if (!st_reg.departure_pending)
                begin
                    st_next.departure_start   = now_ms;
                    st_next.departure_pending = 1'b1;
                end
                else if (departure_elapsed >= cfg.departure_debounce_ms)
                begin
                    st_next.present           = 1'b0;
                    st_next.baseline_locked   = 1'b0;
                    st_next.baseline_start    = 32'd0;
                    st_next.departure_start   = 32'd0;
                    st_next.departure_pending = 1'b0;
                end
            end
            else
            begin
                st_next.departure_start   = 32'd0;
                st_next.departure_pending = 1'b0;
                if (lean_in)
                begin
                    st_next.baseline_distance = distance_mm;
                    st_next.baseline_start    = now_ms;
                    st_next.baseline_locked   = 1'b0;
                    wake                      = 1'b1;
                end
                else if (diff <= cfg.tolerance_mm)
                begin
                    // A start time of zero is read as unset.
                    if (st_reg.baseline_start == 32'd0)
                    begin
                        st_next.baseline_start = now_ms;
                    end
                    else if (!st_reg.baseline_locked &&
                             (baseline_elapsed >= cfg.lock_time_ms))
                    begin
                        st_next.baseline_locked = 1'b1;
                    end
                end
                else
                begin
                    st_next.baseline_distance = distance_mm;
                    st_next.baseline_start    = now_ms;
                    st_next.baseline_locked   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

    assign result.occupied            = st_next.present;
    assign result.wake                = wake;
    assign result.baseline_locked_out = st_next.baseline_locked;
    assign result.baseline_mm         = st_next.baseline_distance;

endmodule

// ===== rtl/desk_presence_filter_top.sv =====
// Desk presence filter. Each request on the sample channel carries one distance
// reading in millimetres and a wrapping millisecond timestamp, and produces exactly
// one request on the result channel with the occupancy flag, a wake flag for that
// sample, the baseline lock flag and the current baseline distance. The block takes
// one sample per clock: a sample is captured in an input register, evaluated against
// the filter state in a single pass of compare and subtract logic, and the answer is
// held in a result register, so the result is offered once the sample has passed the
// input register and then the result register. Throughput is one sample per cycle,
// bounded only by the result register; a stalled result holds the sample stage, and
// the input accepts again as soon as the result register drains.
// Configuration registers are written through the plain write port and take effect
// for samples evaluated after the write; they should only be changed while no sample
// is in flight.
module desk_presence_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    dpf_in_if.sink                         sample,
    dpf_out_if.source                      result,
    input  logic                           cfg_wr_en,
    input  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dpf_pkg::cfg_t    cfg;
    dpf_pkg::result_t core_result;

    // Input stage: the sample waiting to be evaluated.
    logic        in_valid_reg;
    logic [15:0] in_distance_reg;
    logic [31:0] in_now_reg;

    // Result stage: the answer waiting to be taken.
    logic             out_valid_reg;
    dpf_pkg::result_t out_result_reg;

    logic advance;
    logic sample_take;

    // The sample stage moves on whenever the result register is free or drains
    // in the same cycle; the filter state updates exactly then.
    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign sample_take = sample.valid && sample.ready;

    dpf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dpf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .distance_mm (in_distance_reg),
        .now_ms      (in_now_reg),
        .cfg         (cfg),
        .result      (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= sample_take || (in_valid_reg && !advance);
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            in_distance_reg <= sample.distance_mm;
            in_now_reg      <= sample.now_ms;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.occupied            = out_result_reg.occupied;
    assign result.wake                = out_result_reg.wake;
    assign result.baseline_locked_out = out_result_reg.baseline_locked_out;
    assign result.baseline_mm         = out_result_reg.baseline_mm;

endmodule
